/* hw/rtl/rectilinear_grid_laplacian_core_macros.svh */
// Assertion helpers for the RTL controller.
`ifndef RECTILINEAR_GRID_LAPLACIAN_CORE_MACROS_SVH
`define RECTILINEAR_GRID_LAPLACIAN_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGL_CHECK(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGL_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rgl_pkg.sv */
package rgl_pkg;

  localparam int SIZE_W  = 7;
  localparam int POS_W   = 6;
  localparam int DATA_W  = 32;
  localparam int LAP_W   = 48;
  localparam int STAT_W  = 2;
  localparam int SXY_W   = 14;
  localparam int IDX_W   = 22;
  localparam int DIFF_W  = 33;
  localparam int SLOPE_W = 51;
  localparam int DIVN_W  = 68;
  localparam int DIVD_W  = 33;
  localparam int SUM_W   = 50;

  localparam logic [2:0] ACT_LOAD_X = 3'd0;
  localparam logic [2:0] ACT_LOAD_Y = 3'd1;
  localparam logic [2:0] ACT_LOAD_Z = 3'd2;
  localparam logic [2:0] ACT_LOAD_V = 3'd3;
  localparam logic [2:0] ACT_QUERY  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_SPAN = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] DSEL_S21  = 2'd0;
  localparam logic [1:0] DSEL_S32  = 2'd1;
  localparam logic [1:0] DSEL_TERM = 2'd2;

  typedef struct packed {
    logic              in_load;
    logic              chk_load;
    logic              idx_load;
    logic              grid_we;
    logic              ax_load;
    logic              rd_issue;
    logic              rd_capture;
    logic              span_load;
    logic              div_start;
    logic              div_capture;
    logic              acc;
    logic              res_load;
    logic [1:0]        axis;
    logic [1:0]        div_sel;
    logic [STAT_W-1:0] res_code;
  } rgl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic is_load_v;
    logic range_ok;
    logic load_ok;
    logic axis_used;
    logic zero_span;
    logic div_busy;
    logic div_done;
    logic out_free;
  } rgl_stat_t;

endpackage

/* hw/rtl/rgl_item_if.sv */
interface rgl_item_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          action;
  logic [rgl_pkg::POS_W-1:0]           pos_i;
  logic [rgl_pkg::POS_W-1:0]           pos_j;
  logic [rgl_pkg::POS_W-1:0]           pos_k;
  logic signed [rgl_pkg::DATA_W-1:0]   datum;

  modport source(output valid, action, pos_i, pos_j, pos_k, datum, input ready);
  modport sink(input valid, action, pos_i, pos_j, pos_k, datum, output ready);
endinterface

/* hw/rtl/rgl_result_if.sv */
interface rgl_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [rgl_pkg::LAP_W-1:0]  laplacian;
  logic [rgl_pkg::STAT_W-1:0]        status;

  modport source(output valid, laplacian, status, input ready);
  modport sink(input valid, laplacian, status, output ready);
endinterface

/* hw/rtl/rectilinear_grid_laplacian_core.sv */
// Laplacian of a scalar field on a rectilinear grid of up to AXIS_MAX points per axis and
// GRID_DEPTH values. Items load x/y/z coordinates and grid values (Q16.16), and a query
// returns the sum of the per-axis three-point second derivatives (Q32.16, saturated) with a
// status. Items are handled one at a time; a query runs the bit-serial divider, which does
// up to three divisions for every axis with more than two points. A finished result waits
// in an output register while the next item is taken in. Sizes are written through the APB
// port at byte addresses 0, 4 and 8.
module rectilinear_grid_laplacian_core #(
  parameter int AXIS_MAX   = 64,
  parameter int GRID_DEPTH = 16384
) (
  input  logic                clk,
  input  logic                rst,
  rgl_item_if.sink            item,
  rgl_result_if.source        result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  logic [rgl_pkg::SIZE_W-1:0] size_x, size_y, size_z;
  logic                       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= rgl_pkg::SIZE_W'(1);
      size_y <= rgl_pkg::SIZE_W'(1);
      size_z <= rgl_pkg::SIZE_W'(1);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_SIZE_X: size_x <= pwdata[rgl_pkg::SIZE_W-1:0];
        REG_SIZE_Y: size_y <= pwdata[rgl_pkg::SIZE_W-1:0];
        REG_SIZE_Z: size_z <= pwdata[rgl_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SIZE_X: prdata = 32'(size_x);
      REG_SIZE_Y: prdata = 32'(size_y);
      REG_SIZE_Z: prdata = 32'(size_z);
      default:    prdata = '0;
    endcase
  end

  rgl_pkg::rgl_cmd_t  cmd;
  rgl_pkg::rgl_stat_t st;

  rgl_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(item.valid), .in_ready(item.ready),
    .cmd(cmd), .st(st)
  );

  rgl_datapath #(.AXIS_MAX(AXIS_MAX), .GRID_DEPTH(GRID_DEPTH)) u_dp (
    .clk(clk), .rst(rst),
    .size_x(size_x), .size_y(size_y), .size_z(size_z),
    .in_action(item.action), .in_pos_i(item.pos_i), .in_pos_j(item.pos_j),
    .in_pos_k(item.pos_k), .in_datum(item.datum),
    .cmd(cmd), .st(st),
    .out_valid(result.valid), .out_ready(result.ready),
    .out_laplacian(result.laplacian), .out_status(result.status)
  );
endmodule

/* hw/rtl/rgl_ram.sv */
module rgl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/rgl_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module rgl_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rgl_pkg::DIVN_W-1:0]  dividend,
  input  logic [rgl_pkg::DIVD_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [rgl_pkg::DIVN_W-1:0]  quotient
);
  localparam int CNT_W = $clog2(rgl_pkg::DIVN_W + 1);

  logic [rgl_pkg::DIVD_W-1:0] rem;
  logic [rgl_pkg::DIVD_W-1:0] den;
  logic [rgl_pkg::DIVN_W-1:0] dq;
  logic [CNT_W-1:0]           cnt;
  logic [rgl_pkg::DIVD_W:0]   part;
  logic [rgl_pkg::DIVD_W+1:0] trial;
  logic                       ge;

  always_comb begin
    part  = {rem, dq[rgl_pkg::DIVN_W-1]};
    trial = {1'b0, part} - {2'b00, den};
    ge    = !trial[rgl_pkg::DIVD_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(rgl_pkg::DIVN_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      dq  <= dividend;
    end else if (busy) begin
      rem <= ge ? trial[rgl_pkg::DIVD_W-1:0] : part[rgl_pkg::DIVD_W-1:0];
      dq  <= {dq[rgl_pkg::DIVN_W-2:0], ge};
    end
  end

  assign quotient = dq;
endmodule

/* hw/rtl/rgl_datapath.sv */
module rgl_datapath #(
  parameter int AXIS_MAX   = 64,
  parameter int GRID_DEPTH = 16384
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [rgl_pkg::SIZE_W-1:0]         size_x,
  input  logic [rgl_pkg::SIZE_W-1:0]         size_y,
  input  logic [rgl_pkg::SIZE_W-1:0]         size_z,
  input  logic [2:0]                         in_action,
  input  logic [rgl_pkg::POS_W-1:0]          in_pos_i,
  input  logic [rgl_pkg::POS_W-1:0]          in_pos_j,
  input  logic [rgl_pkg::POS_W-1:0]          in_pos_k,
  input  logic signed [rgl_pkg::DATA_W-1:0]  in_datum,
  input  rgl_pkg::rgl_cmd_t                  cmd,
  output rgl_pkg::rgl_stat_t                 st,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rgl_pkg::LAP_W-1:0]   out_laplacian,
  output logic [rgl_pkg::STAT_W-1:0]         out_status
);
  localparam int GAW = $clog2(GRID_DEPTH);
  localparam int CAW = $clog2(AXIS_MAX);
  localparam int DW  = rgl_pkg::DATA_W;
  localparam int IW  = rgl_pkg::IDX_W;
  localparam int SW  = rgl_pkg::SLOPE_W;
  localparam int NW  = rgl_pkg::DIVN_W;
  localparam int LW  = rgl_pkg::LAP_W;
  localparam int UW  = rgl_pkg::SUM_W;
  localparam int FW  = rgl_pkg::DIFF_W;

  // Latched item.
  logic [2:0]                    act_r;
  logic [rgl_pkg::POS_W-1:0]     i_r, j_r, k_r;
  logic signed [DW-1:0]          datum_r;
  logic [rgl_pkg::SXY_W-1:0]     sxy;
  logic [IW-1:0]                 idx;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      act_r   <= in_action;
      i_r     <= in_pos_i;
      j_r     <= in_pos_j;
      k_r     <= in_pos_k;
      datum_r <= in_datum;
    end
    if (cmd.chk_load) begin
      sxy <= size_x * size_y;
    end
  end

  // Point address and range checks.
  logic [19:0] k_term;
  logic [12:0] j_term;
  logic [20:0] total;
  logic [IW-1:0] idx_c;
  logic in_rng, size_ok;

  always_comb begin
    k_term  = k_r * sxy;
    j_term  = j_r * size_x;
    total   = sxy * size_z;
    idx_c   = IW'(k_term) + IW'(j_term) + IW'(i_r);
    in_rng  = (i_r < size_x) && (j_r < size_y) && (k_r < size_z);
    size_ok = (int'(size_x) <= AXIS_MAX) && (int'(size_y) <= AXIS_MAX) &&
              (int'(size_z) <= AXIS_MAX) && (int'(total) <= GRID_DEPTH);
  end

  assign st.is_query  = (act_r == rgl_pkg::ACT_QUERY);
  assign st.is_load_v = (act_r == rgl_pkg::ACT_LOAD_V);
  assign st.range_ok  = in_rng && size_ok;
  assign st.load_ok   = in_rng && (int'(idx_c) < GRID_DEPTH);

  // Axis selection.
  logic [rgl_pkg::POS_W-1:0]  ax_p;
  logic [rgl_pkg::SIZE_W-1:0] ax_n;
  logic [IW-1:0]              ax_s;
  logic                       interior;

  always_comb begin
    unique case (cmd.axis)
      rgl_pkg::AXIS_X: begin
        ax_p = i_r;
        ax_n = size_x;
        ax_s = IW'(1);
      end
      rgl_pkg::AXIS_Y: begin
        ax_p = j_r;
        ax_n = size_y;
        ax_s = IW'(size_x);
      end
      default: begin
        ax_p = k_r;
        ax_n = size_z;
        ax_s = IW'(sxy);
      end
    endcase
    interior = (ax_p != '0) && (rgl_pkg::SIZE_W'(ax_p) < ax_n - rgl_pkg::SIZE_W'(1));
  end

  assign st.axis_used = (ax_n > rgl_pkg::SIZE_W'(2));

  // Stencil walk over the stores.
  logic [IW-1:0]  gaddr, gstep;
  logic [CAW-1:0] caddr;
  logic           cup;

  always_ff @(posedge clk) begin
    if (cmd.ax_load) begin
      if (interior) begin
        gaddr <= idx - ax_s;
        gstep <= ax_s;
        caddr <= CAW'(ax_p) - CAW'(1);
        cup   <= 1'b1;
      end else if (ax_p == '0) begin
        gaddr <= idx;
        gstep <= ax_s;
        caddr <= '0;
        cup   <= 1'b1;
      end else begin
        gaddr <= idx;
        gstep <= IW'(0) - ax_s;
        caddr <= CAW'(ax_n - rgl_pkg::SIZE_W'(1));
        cup   <= 1'b0;
      end
    end else if (cmd.rd_issue) begin
      gaddr <= gaddr + gstep;
      caddr <= cup ? caddr + CAW'(1) : caddr - CAW'(1);
    end
  end

  logic [DW-1:0] g_rdata, cx_rdata, cy_rdata, cz_rdata, c_rdata;
  logic          wx, wy, wz;

  assign wx = cmd.in_load && (in_action == rgl_pkg::ACT_LOAD_X) && (int'(in_pos_i) < AXIS_MAX);
  assign wy = cmd.in_load && (in_action == rgl_pkg::ACT_LOAD_Y) && (int'(in_pos_j) < AXIS_MAX);
  assign wz = cmd.in_load && (in_action == rgl_pkg::ACT_LOAD_Z) && (int'(in_pos_k) < AXIS_MAX);

  rgl_ram #(.WIDTH(DW), .DEPTH(GRID_DEPTH)) u_grid (
    .clk(clk), .we(cmd.grid_we), .waddr(idx_c[GAW-1:0]), .wdata(datum_r),
    .raddr(gaddr[GAW-1:0]), .rdata(g_rdata)
  );
  rgl_ram #(.WIDTH(DW), .DEPTH(AXIS_MAX)) u_xc (
    .clk(clk), .we(wx), .waddr(CAW'(in_pos_i)), .wdata(in_datum),
    .raddr(caddr), .rdata(cx_rdata)
  );
  rgl_ram #(.WIDTH(DW), .DEPTH(AXIS_MAX)) u_yc (
    .clk(clk), .we(wy), .waddr(CAW'(in_pos_j)), .wdata(in_datum),
    .raddr(caddr), .rdata(cy_rdata)
  );
  rgl_ram #(.WIDTH(DW), .DEPTH(AXIS_MAX)) u_zc (
    .clk(clk), .we(wz), .waddr(CAW'(in_pos_k)), .wdata(in_datum),
    .raddr(caddr), .rdata(cz_rdata)
  );

  always_comb begin
    unique case (cmd.axis)
      rgl_pkg::AXIS_X: c_rdata = cx_rdata;
      rgl_pkg::AXIS_Y: c_rdata = cy_rdata;
      default:         c_rdata = cz_rdata;
    endcase
  end

  // The three points shift in so that v1/c1 ends up as the first one read.
  logic signed [DW-1:0] v1, v2, v3, c1, c2, c3;
  logic signed [FW-1:0] d21, d32, d31, dv21, dv32;

  always_ff @(posedge clk) begin
    if (cmd.rd_capture) begin
      v1 <= v2;
      v2 <= v3;
      v3 <= g_rdata;
      c1 <= c2;
      c2 <= c3;
      c3 <= c_rdata;
    end
    if (cmd.span_load) begin
      d21  <= FW'(c2) - FW'(c1);
      d32  <= FW'(c3) - FW'(c2);
      d31  <= FW'(c3) - FW'(c1);
      dv21 <= FW'(v2) - FW'(v1);
      dv32 <= FW'(v3) - FW'(v2);
    end
  end

  assign st.zero_span = (d21 == '0) || (d32 == '0) || (d31 == '0);

  // Divider operands.
  logic signed [SW-1:0] s21, s32;
  logic signed [SW:0]   sdiff;
  logic signed [FW-1:0] num_s, den_s;
  logic [FW-1:0]        num_m, den_m;
  logic [SW:0]          diff_m;
  logic [NW-1:0]        dividend;
  logic                 neg_c, div_neg;
  logic [NW-1:0]        quot;

  always_comb begin
    sdiff  = (SW+1)'(s32) - (SW+1)'(s21);
    diff_m = sdiff[SW] ? (SW+1)'(-sdiff) : (SW+1)'(sdiff);
    unique case (cmd.div_sel)
      rgl_pkg::DSEL_S21: begin
        num_s = dv21;
        den_s = d21;
      end
      rgl_pkg::DSEL_S32: begin
        num_s = dv32;
        den_s = d32;
      end
      default: begin
        num_s = dv21;
        den_s = d31;
      end
    endcase
    num_m = num_s[FW-1] ? FW'(-num_s) : FW'(num_s);
    den_m = den_s[FW-1] ? FW'(-den_s) : FW'(den_s);
    if (cmd.div_sel == rgl_pkg::DSEL_TERM) begin
      dividend = NW'(diff_m) << 17;
      neg_c    = sdiff[SW] ^ den_s[FW-1];
    end else begin
      dividend = NW'(num_m) << 16;
      neg_c    = num_s[FW-1] ^ den_s[FW-1];
    end
  end

  rgl_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(dividend),
    .divisor(den_m), .busy(st.div_busy), .done(st.div_done), .quotient(quot)
  );

  logic signed [SW-1:0] slope_q;
  logic signed [LW-1:0] term, term_q;
  logic                 q_big;

  always_comb begin
    slope_q = div_neg ? SW'(0) - SW'(quot) : SW'(quot);
    q_big   = |quot[NW-1:LW-1];
    if (div_neg) begin
      term_q = q_big ? {1'b1, {(LW-1){1'b0}}} : LW'(0) - quot[LW-1:0];
    end else begin
      term_q = q_big ? {1'b0, {(LW-1){1'b1}}} : quot[LW-1:0];
    end
  end

  logic signed [UW-1:0] sum;
  logic signed [LW-1:0] sum_sat;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_neg <= neg_c;
    end
    if (cmd.div_capture) begin
      unique case (cmd.div_sel)
        rgl_pkg::DSEL_S21: s21 <= slope_q;
        rgl_pkg::DSEL_S32: s32 <= slope_q;
        default:           term <= term_q;
      endcase
    end
    if (cmd.idx_load) begin
      idx <= idx_c;
      sum <= '0;
    end else if (cmd.acc) begin
      sum <= sum + UW'(term);
    end
  end

  always_comb begin
    if (sum[UW-1:LW-1] == {(UW-LW+1){1'b0}} || sum[UW-1:LW-1] == {(UW-LW+1){1'b1}}) begin
      sum_sat = sum[LW-1:0];
    end else if (sum[UW-1]) begin
      sum_sat = {1'b1, {(LW-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(LW-1){1'b1}}};
    end
  end

  // Result register.
  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_laplacian <= (cmd.res_code == rgl_pkg::ST_OK) ? sum_sat : '0;
      out_status    <= cmd.res_code;
    end
  end
endmodule

/* hw/rtl/rgl_controller.sv */
`include "rectilinear_grid_laplacian_core_macros.svh"

module rgl_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output rgl_pkg::rgl_cmd_t  cmd,
  input  rgl_pkg::rgl_stat_t st
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHK1  = 10'b0000000010,
    S_CHK2  = 10'b0000000100,
    S_AXSEL = 10'b0000001000,
    S_READ  = 10'b0000010000,
    S_SPAN  = 10'b0000100000,
    S_DST   = 10'b0001000000,
    S_DWT   = 10'b0010000000,
    S_ACC   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t                      state, state_next;
  logic [1:0]                  axis, axis_next;
  logic [1:0]                  rcnt, rcnt_next;
  logic [1:0]                  dsel, dsel_next;
  logic [rgl_pkg::STAT_W-1:0]  code, code_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    axis_next  = axis;
    rcnt_next  = rcnt;
    dsel_next  = dsel;
    code_next  = code;
    cmd          = '0;
    cmd.axis     = axis;
    cmd.div_sel  = dsel;
    cmd.res_code = code;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_CHK1;
        end
      end
      S_CHK1: begin
        cmd.chk_load = 1'b1;
        state_next   = (st.is_query || st.is_load_v) ? S_CHK2 : S_IDLE;
      end
      S_CHK2: begin
        if (st.is_load_v) begin
          cmd.grid_we = st.load_ok;
          state_next  = S_IDLE;
        end else if (st.range_ok) begin
          cmd.idx_load = 1'b1;
          axis_next    = rgl_pkg::AXIS_X;
          state_next   = S_AXSEL;
        end else begin
          code_next  = rgl_pkg::ST_RANGE;
          state_next = S_FIN;
        end
      end
      S_AXSEL: begin
        if (st.axis_used) begin
          cmd.ax_load = 1'b1;
          rcnt_next   = '0;
          state_next  = S_READ;
        end else if (axis == rgl_pkg::AXIS_Z) begin
          code_next  = rgl_pkg::ST_OK;
          state_next = S_FIN;
        end else begin
          axis_next = axis + 2'd1;
        end
      end
      S_READ: begin
        // Issue three reads and capture each one in the cycle after it is issued.
        cmd.rd_issue   = (rcnt != 2'd3);
        cmd.rd_capture = (rcnt != 2'd0);
        rcnt_next      = rcnt + 2'd1;
        if (rcnt == 2'd3) begin
          state_next = S_SPAN;
        end
      end
      S_SPAN: begin
        cmd.span_load = 1'b1;
        dsel_next     = rgl_pkg::DSEL_S21;
        state_next    = S_DST;
      end
      S_DST: begin
        if (st.zero_span) begin
          code_next  = rgl_pkg::ST_ZERO_SPAN;
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DWT;
        end
      end
      S_DWT: begin
        if (st.div_done) begin
          cmd.div_capture = 1'b1;
          if (dsel == rgl_pkg::DSEL_TERM) begin
            state_next = S_ACC;
          end else begin
            dsel_next  = dsel + 2'd1;
            state_next = S_DST;
          end
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (axis == rgl_pkg::AXIS_Z) begin
          code_next  = rgl_pkg::ST_OK;
          state_next = S_FIN;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_AXSEL;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= '0;
      rcnt  <= '0;
      dsel  <= '0;
      code  <= rgl_pkg::ST_OK;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      rcnt  <= rcnt_next;
      dsel  <= dsel_next;
      code  <= code_next;
    end
  end

  `RGL_CHECK(a_idle_div_quiet, clk, rst, state == S_IDLE, !st.div_busy, "divider busy while idle")
  `RGL_CHECK(a_result_slot_free, clk, rst, cmd.res_load, st.out_free, "result overwritten")
  `RGL_CHECK_NEXT(a_div_runs, clk, rst, cmd.div_start, st.div_busy, "divider did not start")
endmodule

/* verif/tb_rectilinear_grid_laplacian_core.sv */
`timescale 1ns / 1ps

module tb_rectilinear_grid_laplacian_core;

  localparam int GRID_N = 16384;
  localparam int AXIS_N = 64;
  localparam longint LAP_HI = 64'sd140737488355327;
  localparam longint LAP_LO = -LAP_HI - 1;
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST = 3'd7;
  localparam logic [3:0] REG_SIZE_X = 4'd0;
  localparam logic [3:0] REG_SIZE_Y = 4'd4;
  localparam logic [3:0] REG_SIZE_Z = 4'd8;
  localparam int DRAIN_CYCLES = 800;

  typedef struct {
    logic signed [rgl_pkg::LAP_W-1:0] lap;
    logic [rgl_pkg::STAT_W-1:0] st;
  } lap_res_t;

  // Mirror of the grid and coordinate stores, plus the queue of Laplacians still owed.
  class lap_tracker;
    int grid[GRID_N];
    int xc[AXIS_N];
    int yc[AXIS_N];
    int zc[AXIS_N];
    int unsigned sx = 1, sy = 1, sz = 1;
    lap_res_t due[$];
    int errors = 0;

    function void set_size(logic [3:0] addr, int unsigned v);
      v = v & 7'h7F;
      case (addr)
        REG_SIZE_X: sx = v;
        REG_SIZE_Y: sy = v;
        REG_SIZE_Z: sz = v;
        default: ;
      endcase
    endfunction

    // (num * 2^17) / den, truncated toward zero and clipped to 48 bits.
    function longint span_term(longint num, longint den);
      logic [127:0] m, d, q;
      bit neg;
      neg = (num < 0) != (den < 0);
      m = 128'(num < 0 ? -num : num);
      m = m << 17;
      d = 128'(den < 0 ? -den : den);
      q = m / d;
      if (neg) return (q > 128'(LAP_HI)) ? LAP_LO : -longint'(q);
      return (q > 128'(LAP_HI)) ? LAP_HI : longint'(q);
    endfunction

    function bit second_diff(longint v1, longint v2, longint v3,
                             longint x1, longint x2, longint x3, output longint t);
      longint d21, d32, d31, s21, s32;
      d21 = x2 - x1;
      d32 = x3 - x2;
      d31 = x3 - x1;
      t = 0;
      if (d21 == 0 || d32 == 0 || d31 == 0) return 0;
      s21 = ((v2 - v1) * 65536) / d21;
      s32 = ((v3 - v2) * 65536) / d32;
      t = span_term(s32 - s21, d31);
      return 1;
    endfunction

    function longint gv(int unsigned a);
      return (a < GRID_N) ? longint'(grid[a]) : 0;
    endfunction

    function bit axis_term(int unsigned idx, int unsigned p, int unsigned n,
                           int unsigned s, int c[AXIS_N], output longint t);
      if (p > 0 && p < n - 1)
        return second_diff(gv(idx - s), gv(idx), gv(idx + s), c[p-1], c[p], c[p+1], t);
      if (p == 0)
        return second_diff(gv(idx), gv(idx + s), gv(idx + 2*s), c[0], c[1], c[2], t);
      return second_diff(gv(idx), gv(idx - s), gv(idx - 2*s), c[n-1], c[n-2], c[n-3], t);
    endfunction

    function void note_item(logic [2:0] act, int unsigned i, int unsigned j,
                            int unsigned k, logic [31:0] d);
      lap_res_t r;
      longint sum, t;
      int unsigned idx, sxy;
      case (act)
        rgl_pkg::ACT_LOAD_X: xc[i] = d;
        rgl_pkg::ACT_LOAD_Y: yc[j] = d;
        rgl_pkg::ACT_LOAD_Z: zc[k] = d;
        rgl_pkg::ACT_LOAD_V: begin
          if (i < sx && j < sy && k < sz) begin
            idx = (k * sy + j) * sx + i;
            if (idx < GRID_N) grid[idx] = d;
          end
        end
        rgl_pkg::ACT_QUERY: begin
          r.lap = '0;
          r.st = rgl_pkg::ST_RANGE;
          if (!(i >= sx || j >= sy || k >= sz || sx > AXIS_N || sy > AXIS_N ||
                sz > AXIS_N || sx * sy * sz > GRID_N)) begin
            r.st = rgl_pkg::ST_OK;
            sum = 0;
            sxy = sx * sy;
            idx = k * sxy + j * sx + i;
            if (sx > 2) begin
              if (!axis_term(idx, i, sx, 1, xc, t)) r.st = rgl_pkg::ST_ZERO_SPAN;
              else sum += t;
            end
            if (r.st == rgl_pkg::ST_OK && sy > 2) begin
              if (!axis_term(idx, j, sy, sx, yc, t)) r.st = rgl_pkg::ST_ZERO_SPAN;
              else sum += t;
            end
            if (r.st == rgl_pkg::ST_OK && sz > 2) begin
              if (!axis_term(idx, k, sz, sxy, zc, t)) r.st = rgl_pkg::ST_ZERO_SPAN;
              else sum += t;
            end
            if (r.st == rgl_pkg::ST_OK) begin
              if (sum > LAP_HI) sum = LAP_HI;
              if (sum < LAP_LO) sum = LAP_LO;
              r.lap = sum[rgl_pkg::LAP_W-1:0];
            end
          end
          due.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [rgl_pkg::LAP_W-1:0] lap,
                               logic [rgl_pkg::STAT_W-1:0] st);
      lap_res_t r;
      if (due.size() == 0) begin
        $error("unexpected result: laplacian %0d status %0d", lap, st);
        errors++;
        return;
      end
      r = due.pop_front();
      if (lap !== r.lap) begin
        $error("laplacian: expected %0d, actual %0d", r.lap, lap);
        errors++;
      end
      if (st !== r.st) begin
        $error("status: expected %0d, actual %0d", r.st, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  bit calm = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_left = 0;
  lap_tracker sb = new();

  rgl_item_if item_ch();
  rgl_result_if res_ch();

  rectilinear_grid_laplacian_core dut (
    .clk(clk), .rst(rst), .item(item_ch.sink), .result(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    item_ch.valid = 1'b0;
    item_ch.action = rgl_pkg::ACT_LOAD_X;
    item_ch.pos_i = '0;
    item_ch.pos_j = '0;
    item_ch.pos_k = '0;
    item_ch.datum = '0;
    res_ch.ready = 1'b0;
  end

  initial forever #4 clk = ~clk;

  initial begin
    #20ms;
    $display("rectilinear_grid_laplacian_core verification failed");
    $finish;
  end

  // Result side: random back-pressure plus one long hold-off to fill the block.
  initial forever begin
    @(posedge clk);
    if (hold_req && !hold_done) begin
      hold_left = 4000;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
    end
  end

  // Signals are stable at the falling edge, so a transfer seen here completes at the next rise.
  initial forever begin
    @(negedge clk);
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.laplacian, res_ch.status);
  end

  task automatic send(logic [2:0] act, int unsigned i, int unsigned j, int unsigned k,
                      logic [31:0] d);
    bit took;
    if (!calm && $urandom_range(0, 99) < 16) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.action <= act;
    item_ch.pos_i <= i[5:0];
    item_ch.pos_j <= j[5:0];
    item_ch.pos_k <= k[5:0];
    item_ch.datum <= d;
    do begin
      @(negedge clk);
      took = item_ch.ready;
      @(posedge clk);
    end while (!took);
    sb.note_item(act, i[5:0], j[5:0], k[5:0], d);
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] addr, int unsigned v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_size(addr, v);
  endtask

  function automatic int unsigned pick(int unsigned s);
    if (s == 0) return 0;
    return $urandom_range(0, (s > AXIS_N ? AXIS_N : s) - 1);
  endfunction

  // New sizes, then every coordinate and grid entry a query can reach gets written.
  task automatic setup_grid(int unsigned nx, int unsigned ny, int unsigned nz);
    write_reg(REG_SIZE_X, nx);
    write_reg(REG_SIZE_Y, ny);
    write_reg(REG_SIZE_Z, nz);
    for (int a = 0; a < nx && a < AXIS_N; a++) send(rgl_pkg::ACT_LOAD_X, a, 0, 0, $urandom);
    for (int a = 0; a < ny && a < AXIS_N; a++) send(rgl_pkg::ACT_LOAD_Y, 0, a, 0, $urandom);
    for (int a = 0; a < nz && a < AXIS_N; a++) send(rgl_pkg::ACT_LOAD_Z, 0, 0, a, $urandom);
    if (nx <= AXIS_N && ny <= AXIS_N && nz <= AXIS_N && nx * ny * nz <= GRID_N)
      for (int k = 0; k < nz; k++)
        for (int j = 0; j < ny; j++)
          for (int i = 0; i < nx; i++) send(rgl_pkg::ACT_LOAD_V, i, j, k, $urandom);
  endtask

  task automatic random_items(int n);
    int unsigned sel, i, j, k, ax, a;
    logic [31:0] d;
    for (int c = 0; c < n; c++) begin
      sel = $urandom_range(0, 99);
      i = pick(sb.sx);
      j = pick(sb.sy);
      k = pick(sb.sz);
      d = $urandom;
      ax = $urandom_range(0, 2);
      if (sel < 35) begin
        send(rgl_pkg::ACT_QUERY, i, j, k, d);
      end else if (sel < 42) begin
        // One index pushed past its size where the size leaves room.
        if (ax == 0 && sb.sx < AXIS_N) i = $urandom_range(sb.sx, AXIS_N - 1);
        if (ax == 1 && sb.sy < AXIS_N) j = $urandom_range(sb.sy, AXIS_N - 1);
        if (ax == 2 && sb.sz < AXIS_N) k = $urandom_range(sb.sz, AXIS_N - 1);
        send(rgl_pkg::ACT_QUERY, i, j, k, d);
      end else if (sel < 72) begin
        send(rgl_pkg::ACT_LOAD_V, i, j, k, d);
      end else if (sel < 80) begin
        // A copied neighbor coordinate makes a zero spacing.
        if (ax == 0) begin
          a = i;
          if ($urandom_range(0, 2) == 0) d = sb.xc[a == 0 ? 1 : a - 1];
          send(rgl_pkg::ACT_LOAD_X, a, j, k, d);
        end else if (ax == 1) begin
          a = j;
          if ($urandom_range(0, 2) == 0) d = sb.yc[a == 0 ? 1 : a - 1];
          send(rgl_pkg::ACT_LOAD_Y, i, a, k, d);
        end else begin
          a = k;
          if ($urandom_range(0, 2) == 0) d = sb.zc[a == 0 ? 1 : a - 1];
          send(rgl_pkg::ACT_LOAD_Z, i, j, a, d);
        end
      end else if (sel < 86) begin
        send(rgl_pkg::ACT_LOAD_X + ax[2:0], $urandom_range(0, 63), $urandom_range(0, 63),
             $urandom_range(0, 63), d);
      end else if (sel < 92) begin
        send(rgl_pkg::ACT_LOAD_V, $urandom_range(0, 63), $urandom_range(0, 63),
             $urandom_range(0, 63), d);
      end else begin
        send(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)), $urandom_range(0, 63),
             $urandom_range(0, 63), $urandom_range(0, 63), d);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sizes: no axis is used, so the query reads nothing.
    send(rgl_pkg::ACT_QUERY, 0, 0, 0, 32'h0);
    send(rgl_pkg::ACT_QUERY, 1, 0, 0, 32'h0);
    send(rgl_pkg::ACT_QUERY, 63, 63, 63, 32'hFFFF_FFFF);
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++) send(3'(a), 5, 6, 7, $urandom);
    send(rgl_pkg::ACT_LOAD_X, 63, 0, 0, 32'h8000_0000);
    settle();

    setup_grid(3, 3, 3);
    send(rgl_pkg::ACT_QUERY, 0, 0, 0, 0);
    send(rgl_pkg::ACT_QUERY, 1, 1, 1, 0);
    send(rgl_pkg::ACT_QUERY, 2, 2, 2, 0);
    send(rgl_pkg::ACT_QUERY, 0, 1, 2, 0);
    send(rgl_pkg::ACT_QUERY, 3, 0, 0, 0);
    send(rgl_pkg::ACT_QUERY, 0, 3, 0, 0);
    send(rgl_pkg::ACT_QUERY, 0, 0, 3, 0);
    send(rgl_pkg::ACT_LOAD_X, 1, 0, 0, sb.xc[0]);
    send(rgl_pkg::ACT_QUERY, 1, 1, 1, 0);
    // Unit spacing with extreme values drives the term into saturation.
    send(rgl_pkg::ACT_LOAD_X, 0, 0, 0, 32'h0);
    send(rgl_pkg::ACT_LOAD_X, 1, 0, 0, 32'h1);
    send(rgl_pkg::ACT_LOAD_X, 2, 0, 0, 32'h2);
    send(rgl_pkg::ACT_LOAD_V, 0, 0, 0, 32'h7FFF_FFFF);
    send(rgl_pkg::ACT_LOAD_V, 1, 0, 0, 32'h8000_0000);
    send(rgl_pkg::ACT_LOAD_V, 2, 0, 0, 32'h7FFF_FFFF);
    send(rgl_pkg::ACT_QUERY, 0, 0, 0, 0);
    send(rgl_pkg::ACT_QUERY, 1, 0, 0, 0);
    random_items(80);
    settle();

    setup_grid(5, 4, 2);
    random_items(60);
    settle();

    calm = 1;
    setup_grid(64, 1, 2);
    random_items(40);
    settle();
    calm = 0;

    setup_grid(2, 64, 1);
    random_items(30);
    settle();

    setup_grid(1, 3, 64);
    random_items(30);
    settle();

    setup_grid(64, 64, 5);
    random_items(15);
    settle();

    setup_grid(0, 3, 127);
    random_items(15);
    settle();

    setup_grid(4, 3, 3);
    hold_req = 1;
    random_items(40);
    settle();

    if (sb.due.size() != 0) begin
      $error("%0d expected results never arrived", sb.due.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("rectilinear_grid_laplacian_core verification clean");
    end else begin
      $display("rectilinear_grid_laplacian_core verification failed");
    end
    $finish;
  end

endmodule

/* rectilinear_grid_laplacian_core.f */
+incdir+hw/rtl
hw/rtl/rgl_pkg.sv
hw/rtl/rgl_item_if.sv
hw/rtl/rgl_result_if.sv
hw/rtl/rgl_ram.sv
hw/rtl/rgl_divider.sv
hw/rtl/rgl_datapath.sv
hw/rtl/rgl_controller.sv
hw/rtl/rectilinear_grid_laplacian_core.sv
verif/tb_rectilinear_grid_laplacian_core.sv
